@@ design/eccl_pkg.sv @@
// Package with the item types, table entry types and sequencer states of the claim table.
`default_nettype none

package eccl_pkg;

  localparam int unsigned SLOT_W = 32;
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned KEY_W  = GEN_W + SLOT_W;
  localparam int unsigned BUF_W  = 16;
  localparam int unsigned CTYPE_W = 16;

  localparam logic MODE_CLAIM = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [SLOT_W-1:0]  entity_slot;
    logic [GEN_W-1:0]   entity_generation;
    logic [BUF_W-1:0]   buffer_id;
    logic               is_destroy;
    logic [CTYPE_W-1:0] component_type;
    logic               has_component_type;
  } claim_req_t;

  typedef struct packed {
    logic granted;
    logic table_full;
  } claim_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             whole_set;
    logic [BUF_W-1:0] whole_owner;
  } ent_word_t;

  typedef struct packed {
    logic               valid;
    logic [CTYPE_W-1:0] ctype;
    logic [BUF_W-1:0]   buffer_id;
  } own_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ESCAN,
    ST_OCLR,
    ST_OSCAN,
    ST_DECIDE,
    ST_EMIT
  } eccl_state_e;

endpackage

`default_nettype wire

@@ design/eccl_req_if.sv @@
// Handshake channel that carries claim and clear request items.
`default_nettype none

interface eccl_req_if
  import eccl_pkg::*;
;
  logic       valid;
  logic       ready;
  claim_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/eccl_rsp_if.sv @@
// Handshake channel that carries claim result items.
`default_nettype none

interface eccl_rsp_if
  import eccl_pkg::*;
;
  logic       valid;
  logic       ready;
  claim_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/eccl_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
`default_nettype none

module eccl_ram #(
  parameter int unsigned WIDTH = 82,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ design/entity_claim_conflict_table_core.sv @@
// Claim table core: entity lookup, owner slot scan and claim decision under one sequencer.
// A destroy or typed claim scans the entity table, then its entry's owner slots, and decides;
// one that allocates an entity entry first clears that entry's owner slots, and one that finds
// the entity table full gives table_full after the entity scan. A claim without a type needs no
// scan; a clear wipes the entity table. The next item is accepted when the result is output;
// a waiting result delays the next one. Reset wipes the entity table before the first item.
`default_nettype none

module entity_claim_conflict_table_core
  import eccl_pkg::*;
#(
  parameter int unsigned ENTITY_ENTRIES    = 64,
  parameter int unsigned OWNERS_PER_ENTITY = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  eccl_req_if.sink    req_i,
  eccl_rsp_if.source  rsp_o
);

  localparam int unsigned EIDX_W    = $clog2(ENTITY_ENTRIES);
  localparam int unsigned ECNT_W    = $clog2(ENTITY_ENTRIES + 1);
  localparam int unsigned OWN_DEPTH = ENTITY_ENTRIES * OWNERS_PER_ENTITY;
  localparam int unsigned OADDR_W   = $clog2(OWN_DEPTH);
  localparam int unsigned OCNT_W    = $clog2(OWNERS_PER_ENTITY + 1);
  localparam int unsigned ENT_W     = $bits(ent_word_t);
  localparam int unsigned OWN_W     = $bits(own_word_t);

  localparam logic [EIDX_W-1:0] ELAST = EIDX_W'(ENTITY_ENTRIES - 1);
  localparam logic [ECNT_W-1:0] ENUM  = ECNT_W'(ENTITY_ENTRIES);
  localparam logic [OCNT_W-1:0] OLAST = OCNT_W'(OWNERS_PER_ENTITY - 1);
  localparam logic [OCNT_W-1:0] ONUM  = OCNT_W'(OWNERS_PER_ENTITY);

  eccl_state_e state_q, state_d;

  logic [ECNT_W-1:0] cnt_q, cnt_d;
  logic              ev_q, ev_d;
  logic [EIDX_W-1:0] ev_idx_q, ev_idx_d;
  logic              hit_q, hit_d;
  logic [EIDX_W-1:0] hit_idx_q, hit_idx_d;
  logic              free_q, free_d;
  logic [EIDX_W-1:0] free_idx_q, free_idx_d;
  logic [OCNT_W-1:0] kcnt_q, kcnt_d;
  logic              oev_q, oev_d;
  logic [OCNT_W-1:0] oev_k_q, oev_k_d;
  logic              oconf_q, oconf_d;
  logic              ofound_q, ofound_d;
  logic              ofree_q, ofree_d;
  logic              clr_rsp_q, clr_rsp_d;
  logic              rsp_vld_q, rsp_vld_d;

  claim_req_t        req_q, req_d;
  logic [EIDX_W-1:0] e_q, e_d;
  logic              ws_q, ws_d;
  logic [BUF_W-1:0]  wo_q, wo_d;
  logic [BUF_W-1:0]  ofbuf_q, ofbuf_d;
  logic [OCNT_W-1:0] ofree_k_q, ofree_k_d;
  logic              res_granted_q, res_granted_d;
  logic              res_full_q, res_full_d;
  claim_rsp_t        rsp_q, rsp_d;

  logic               ent_we;
  logic [EIDX_W-1:0]  ent_waddr;
  ent_word_t          ent_wdata;
  logic [EIDX_W-1:0]  ent_raddr;
  logic [ENT_W-1:0]   ent_rbits;
  ent_word_t          ent_rdata;
  logic               own_we;
  logic [OADDR_W-1:0] own_waddr;
  own_word_t          own_wdata;
  logic [OADDR_W-1:0] own_raddr;
  logic [OWN_W-1:0]   own_rbits;
  own_word_t          own_rdata;
  logic [OADDR_W-1:0] own_base;
  logic [KEY_W-1:0]   req_key;

  assign ent_rdata = ent_word_t'(ent_rbits);
  assign own_rdata = own_word_t'(own_rbits);
  assign own_base  = OADDR_W'(e_q) * OADDR_W'(OWNERS_PER_ENTITY);
  assign req_key   = {req_q.entity_generation, req_q.entity_slot};

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  eccl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTITY_ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rbits)
  );

  eccl_ram #(
    .WIDTH (OWN_W),
    .DEPTH (OWN_DEPTH)
  ) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (own_raddr),
    .rdata_o (own_rbits)
  );

  always_comb begin
    logic whole_conf;

    state_d       = state_q;
    cnt_d         = cnt_q;
    ev_d          = 1'b0;
    ev_idx_d      = ev_idx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    kcnt_d        = kcnt_q;
    oev_d         = 1'b0;
    oev_k_d       = oev_k_q;
    oconf_d       = oconf_q;
    ofound_d      = ofound_q;
    ofree_d       = ofree_q;
    clr_rsp_d     = clr_rsp_q;
    rsp_vld_d     = rsp_vld_q && !rsp_o.ready;
    req_d         = req_q;
    e_d           = e_q;
    ws_d          = ws_q;
    wo_d          = wo_q;
    ofbuf_d       = ofbuf_q;
    ofree_k_d     = ofree_k_q;
    res_granted_d = res_granted_q;
    res_full_d    = res_full_q;
    rsp_d         = rsp_q;

    ent_we    = 1'b0;
    ent_waddr = cnt_q[EIDX_W-1:0];
    ent_wdata = '0;
    ent_raddr = cnt_q[EIDX_W-1:0];
    own_we    = 1'b0;
    own_waddr = own_base + OADDR_W'(kcnt_q);
    own_wdata = '0;
    own_raddr = own_base + OADDR_W'(kcnt_q);

    whole_conf = ws_q && (wo_q != req_q.buffer_id);

    unique case (state_q)
      ST_CLEAR: begin
        ent_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q[EIDX_W-1:0] == ELAST) begin
          if (clr_rsp_q) begin
            res_granted_d = 1'b1;
            res_full_d    = 1'b0;
            state_d       = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
          clr_rsp_d = 1'b0;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          req_d  = req_i.payload;
          cnt_d  = '0;
          hit_d  = 1'b0;
          free_d = 1'b0;
          if (req_i.payload.mode == MODE_CLEAR) begin
            clr_rsp_d = 1'b1;
            state_d   = ST_CLEAR;
          end else if (!req_i.payload.is_destroy && !req_i.payload.has_component_type) begin
            res_granted_d = 1'b1;
            res_full_d    = 1'b0;
            state_d       = ST_EMIT;
          end else begin
            state_d = ST_ESCAN;
          end
        end
      end

      ST_ESCAN: begin
        if (cnt_q != ENUM) begin
          ev_d     = 1'b1;
          ev_idx_d = cnt_q[EIDX_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end
        if (ev_q) begin
          if (ent_rdata.valid && (ent_rdata.key == req_key) && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = ev_idx_q;
            ws_d      = ent_rdata.whole_set;
            wo_d      = ent_rdata.whole_owner;
          end
          if (!ent_rdata.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = ev_idx_q;
          end
          if (ev_idx_q == ELAST) begin
            kcnt_d   = '0;
            oconf_d  = 1'b0;
            ofound_d = 1'b0;
            ofree_d  = 1'b0;
            if (hit_d) begin
              e_d     = hit_idx_d;
              state_d = ST_OSCAN;
            end else if (free_d) begin
              e_d       = free_idx_d;
              ws_d      = 1'b0;
              wo_d      = '0;
              ent_we    = 1'b1;
              ent_waddr = free_idx_d;
              ent_wdata = '{valid: 1'b1, key: req_key, whole_set: 1'b0, whole_owner: '0};
              state_d   = ST_OCLR;
            end else begin
              res_granted_d = 1'b0;
              res_full_d    = 1'b1;
              state_d       = ST_EMIT;
            end
          end
        end
      end

      ST_OCLR: begin
        own_we = 1'b1;
        kcnt_d = kcnt_q + 1'b1;
        if (kcnt_q == OLAST) begin
          kcnt_d  = '0;
          state_d = ST_OSCAN;
        end
      end

      ST_OSCAN: begin
        if (kcnt_q != ONUM) begin
          oev_d   = 1'b1;
          oev_k_d = kcnt_q;
          kcnt_d  = kcnt_q + 1'b1;
        end
        if (oev_q) begin
          if (own_rdata.valid) begin
            if (own_rdata.buffer_id != req_q.buffer_id) begin
              oconf_d = 1'b1;
            end
            if (!ofound_q && (own_rdata.ctype == req_q.component_type)) begin
              ofound_d = 1'b1;
              ofbuf_d  = own_rdata.buffer_id;
            end
          end else if (!ofree_q) begin
            ofree_d   = 1'b1;
            ofree_k_d = oev_k_q;
          end
          if (oev_k_q == OLAST) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        res_granted_d = 1'b0;
        res_full_d    = 1'b0;
        if (req_q.is_destroy) begin
          if (!whole_conf && !oconf_q) begin
            ent_we        = 1'b1;
            ent_waddr     = e_q;
            ent_wdata     = '{valid: 1'b1, key: req_key, whole_set: 1'b1,
                              whole_owner: req_q.buffer_id};
            res_granted_d = 1'b1;
          end
        end else if (!whole_conf) begin
          if (ofound_q) begin
            res_granted_d = (ofbuf_q == req_q.buffer_id);
          end else if (ofree_q) begin
            own_we        = 1'b1;
            own_waddr     = own_base + OADDR_W'(ofree_k_q);
            own_wdata     = '{valid: 1'b1, ctype: req_q.component_type,
                              buffer_id: req_q.buffer_id};
            res_granted_d = 1'b1;
          end else begin
            res_full_d = 1'b1;
          end
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d = 1'b1;
          rsp_d     = '{granted: res_granted_q, table_full: res_full_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      ev_q       <= 1'b0;
      ev_idx_q   <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      kcnt_q     <= '0;
      oev_q      <= 1'b0;
      oev_k_q    <= '0;
      oconf_q    <= 1'b0;
      ofound_q   <= 1'b0;
      ofree_q    <= 1'b0;
      clr_rsp_q  <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ev_q       <= ev_d;
      ev_idx_q   <= ev_idx_d;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      kcnt_q     <= kcnt_d;
      oev_q      <= oev_d;
      oev_k_q    <= oev_k_d;
      oconf_q    <= oconf_d;
      ofound_q   <= ofound_d;
      ofree_q    <= ofree_d;
      clr_rsp_q  <= clr_rsp_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    e_q           <= e_d;
    ws_q          <= ws_d;
    wo_q          <= wo_d;
    ofbuf_q       <= ofbuf_d;
    ofree_k_q     <= ofree_k_d;
    res_granted_q <= res_granted_d;
    res_full_q    <= res_full_d;
    rsp_q         <= rsp_d;
  end

endmodule

`default_nettype wire

@@ tb/tb_entity_claim_conflict_table_core.sv @@
// Self-checking testbench of the claim table core with directed and random claim and clear items.
`default_nettype none

module tb_entity_claim_conflict_table_core;
  import eccl_pkg::*;

  localparam int unsigned TBL_ENTRIES = 64;
  localparam int unsigned TBL_OWNERS  = 8;
  localparam int unsigned ITEM_TOTAL  = 1450;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned QUIET_LO    = 40000;
  localparam int unsigned QUIET_HI    = 70000;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned KEY_POOL_N  = 6;
  localparam int unsigned BUF_POOL_N  = 4;
  localparam int unsigned TYPE_POOL_N = 10;

  logic clk;
  logic rst_n;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;

  eccl_req_if req_ch ();
  eccl_rsp_if rsp_ch ();

  entity_claim_conflict_table_core #(
    .ENTITY_ENTRIES   (TBL_ENTRIES),
    .OWNERS_PER_ENTITY(TBL_OWNERS)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  claim_req_t pending_items[$];
  claim_rsp_t expected_rsp[$];

  logic             ent_used [TBL_ENTRIES];
  logic [KEY_W-1:0] ent_key  [TBL_ENTRIES];
  logic             ent_whole[TBL_ENTRIES];
  logic [BUF_W-1:0] ent_wbuf [TBL_ENTRIES];
  logic               own_used[TBL_ENTRIES*TBL_OWNERS];
  logic [CTYPE_W-1:0] own_type[TBL_ENTRIES*TBL_OWNERS];
  logic [BUF_W-1:0]   own_buf [TBL_ENTRIES*TBL_OWNERS];

  logic [KEY_W-1:0]   key_pool [KEY_POOL_N];
  logic [BUF_W-1:0]   buf_pool [BUF_POOL_N];
  logic [CTYPE_W-1:0] type_pool[TYPE_POOL_N];

  function automatic void table_wipe();
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      ent_used[i]  = 1'b0;
      ent_whole[i] = 1'b0;
    end
    for (int i = 0; i < TBL_ENTRIES*TBL_OWNERS; i++) begin
      own_used[i] = 1'b0;
    end
  endfunction

  function automatic claim_rsp_t claim_decide(claim_req_t r);
    logic [KEY_W-1:0] key;
    int               e;
    int               base;
    int               found;
    int               spare;
    logic             conflict;
    claim_rsp_t       res;
    res = '0;
    if (r.mode == MODE_CLEAR) begin
      table_wipe();
      res.granted = 1'b1;
      return res;
    end
    if (!r.is_destroy && !r.has_component_type) begin
      res.granted = 1'b1;
      return res;
    end
    key = {r.entity_generation, r.entity_slot};
    e = -1;
    for (int i = 0; i < TBL_ENTRIES; i++) begin
      if (e < 0 && ent_used[i] && ent_key[i] == key) e = i;
    end
    if (e < 0) begin
      for (int i = 0; i < TBL_ENTRIES; i++) begin
        if (e < 0 && !ent_used[i]) e = i;
      end
      if (e < 0) begin
        res.table_full = 1'b1;
        return res;
      end
      ent_used[e]  = 1'b1;
      ent_key[e]   = key;
      ent_whole[e] = 1'b0;
      ent_wbuf[e]  = '0;
      for (int k = 0; k < TBL_OWNERS; k++) begin
        own_used[e*TBL_OWNERS + k] = 1'b0;
      end
    end
    base = e * TBL_OWNERS;
    if (r.is_destroy) begin
      conflict = ent_whole[e] && ent_wbuf[e] != r.buffer_id;
      for (int k = 0; k < TBL_OWNERS; k++) begin
        if (own_used[base + k] && own_buf[base + k] != r.buffer_id) conflict = 1'b1;
      end
      if (!conflict) begin
        ent_whole[e] = 1'b1;
        ent_wbuf[e]  = r.buffer_id;
        res.granted  = 1'b1;
      end
    end else if (ent_whole[e] && ent_wbuf[e] != r.buffer_id) begin
      res.granted = 1'b0;
    end else begin
      found = -1;
      spare = -1;
      for (int k = 0; k < TBL_OWNERS; k++) begin
        if (own_used[base + k]) begin
          if (found < 0 && own_type[base + k] == r.component_type) found = base + k;
        end else if (spare < 0) begin
          spare = base + k;
        end
      end
      if (found >= 0) begin
        res.granted = (own_buf[found] == r.buffer_id);
      end else if (spare >= 0) begin
        own_used[spare] = 1'b1;
        own_type[spare] = r.component_type;
        own_buf[spare]  = r.buffer_id;
        res.granted     = 1'b1;
      end else begin
        res.table_full = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic bit side_idles();
    return (cycle_count < QUIET_LO || cycle_count >= QUIET_HI) && ($urandom_range(0, 99) < 19);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_claim(input logic [KEY_W-1:0] key, input logic [BUF_W-1:0] bid,
                           input logic dest, input logic has, input logic [CTYPE_W-1:0] ct);
    claim_req_t r;
    r.mode               = MODE_CLAIM;
    r.entity_generation  = key[KEY_W-1:SLOT_W];
    r.entity_slot        = key[SLOT_W-1:0];
    r.buffer_id          = bid;
    r.is_destroy         = dest;
    r.component_type     = ct;
    r.has_component_type = has;
    pending_items = {pending_items, r};
  endtask

  task automatic add_noise(input logic md);
    claim_req_t r;
    r.mode               = md;
    r.entity_generation  = $urandom();
    r.entity_slot        = $urandom();
    r.buffer_id          = 16'($urandom_range(0, 65535));
    r.is_destroy         = 1'($urandom_range(0, 1));
    r.component_type     = 16'($urandom_range(0, 65535));
    r.has_component_type = 1'($urandom_range(0, 1));
    pending_items = {pending_items, r};
  endtask

  task automatic refresh_pools();
    key_pool[0] = rand_key();
    key_pool[1] = {$urandom(), key_pool[0][SLOT_W-1:0]};
    key_pool[2] = {key_pool[0][KEY_W-1:SLOT_W], $urandom()};
    for (int i = 3; i < KEY_POOL_N; i++) begin
      case ($urandom_range(0, 9))
        0: key_pool[i] = '0;
        1: key_pool[i] = '1;
        default: key_pool[i] = rand_key();
      endcase
    end
    for (int i = 0; i < BUF_POOL_N; i++) begin
      buf_pool[i] = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    end
    for (int i = 0; i < TYPE_POOL_N; i++) begin
      type_pool[i] = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
    end
  endtask

  task automatic build_directed();
    logic [KEY_W-1:0] k_zero;
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_slot;
    k_zero = '0;
    k_ones = '1;
    k_slot = {32'h0000_0000, 32'h0000_0001};
    add_claim(k_ones, 16'hFFFF, 1'b0, 1'b0, 16'hFFFF);
    add_claim(k_zero, 16'h0000, 1'b1, 1'b0, 16'h0000);
    add_claim(k_zero, 16'h0000, 1'b1, 1'b1, 16'h1234);
    add_claim(k_zero, 16'hFFFF, 1'b1, 1'b0, 16'h0000);
    add_claim(k_zero, 16'hFFFF, 1'b0, 1'b1, 16'h0005);
    add_claim(k_zero, 16'h0000, 1'b0, 1'b1, 16'h0000);
    add_claim(k_ones, 16'h0001, 1'b0, 1'b1, 16'hFFFF);
    add_claim(k_ones, 16'h0002, 1'b0, 1'b1, 16'hFFFF);
    add_claim(k_ones, 16'h0001, 1'b0, 1'b1, 16'hFFFF);
    add_claim(k_ones, 16'h0002, 1'b1, 1'b0, 16'h0000);
    add_claim(k_ones, 16'h0001, 1'b1, 1'b0, 16'h0000);
    for (int t = 1; t <= TBL_OWNERS + 1; t++) begin
      add_claim(k_slot, 16'h0003, 1'b0, 1'b1, 16'(t));
    end
    add_noise(MODE_CLEAR);
    add_claim(k_zero, 16'hFFFF, 1'b1, 1'b0, 16'h0000);
    add_claim(k_zero, 16'h0000, 1'b0, 1'b1, 16'h0000);
  endtask

  task automatic build_random();
    int unsigned roll;
    int unsigned pick;
    refresh_pools();
    while (pending_items.size() < ITEM_TOTAL) begin
      roll = $urandom_range(0, 99);
      if (roll < 7) begin
        add_noise(MODE_CLEAR);
      end else if (roll < 11) begin
        for (int i = 0; i < TBL_ENTRIES + 6; i++) begin
          add_claim(rand_key(), 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1,
                    16'($urandom_range(0, 65535)));
        end
      end else if (roll < 21) begin
        for (int i = 0; i < 4; i++) begin
          add_noise(($urandom_range(0, 9) == 0) ? MODE_CLEAR : MODE_CLAIM);
        end
      end else begin
        if ($urandom_range(0, 9) < 3) refresh_pools();
        for (int i = 0; i < 24; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 20) begin
            add_claim(key_pool[$urandom_range(0, KEY_POOL_N-1)],
                      buf_pool[$urandom_range(0, BUF_POOL_N-1)], 1'b1,
                      1'($urandom_range(0, 1)),
                      type_pool[$urandom_range(0, TYPE_POOL_N-1)]);
          end else if (pick < 27) begin
            add_claim(key_pool[$urandom_range(0, KEY_POOL_N-1)],
                      buf_pool[$urandom_range(0, BUF_POOL_N-1)], 1'b0, 1'b0,
                      16'($urandom_range(0, 65535)));
          end else begin
            add_claim(key_pool[$urandom_range(0, KEY_POOL_N-1)],
                      buf_pool[$urandom_range(0, BUF_POOL_N-1)], 1'b0, 1'b1,
                      type_pool[$urandom_range(0, TYPE_POOL_N-1)]);
          end
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_items.size() > 0 && !side_idles()) begin
        req_ch.payload <= pending_items.pop_front();
        req_ch.valid   <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    claim_rsp_t want;
    claim_rsp_t predicted;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predicted = claim_decide(req_ch.payload);
        expected_rsp = {expected_rsp, predicted};
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          error_count++;
          if (error_count <= 100) begin
            $display("%0t unexpected result: expected none, actual granted=%0b table_full=%0b",
                     $time, rsp_ch.payload.granted, rsp_ch.payload.table_full);
          end
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_ch.payload.granted !== want.granted) begin
            error_count++;
            if (error_count <= 100) begin
              $display("%0t granted mismatch: expected %0b, actual %0b",
                       $time, want.granted, rsp_ch.payload.granted);
            end
          end
          if (rsp_ch.payload.table_full !== want.table_full) begin
            error_count++;
            if (error_count <= 100) begin
              $display("%0t table_full mismatch: expected %0b, actual %0b",
                       $time, want.table_full, rsp_ch.payload.table_full);
            end
          end
        end
      end
      rsp_ch.ready <= !side_idles();
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL entity_claim_conflict_table_core");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    table_wipe();
    build_directed();
    build_random();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || req_ch.valid || expected_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      error_count++;
      $display("%0t results missing: expected %0d more, actual 0",
               $time, expected_rsp.size());
    end
    if (error_count == 0) begin
      $display("PASS entity_claim_conflict_table_core");
    end else begin
      $display("FAIL entity_claim_conflict_table_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
